/* rtl/fbdpc_pkg.sv */
// Shared types, constants and helpers for the four-button debounce and press classifier.
// Depends on nothing; every other file of the block imports it.
package fbdpc_pkg;

    localparam int TIME_BITS   = 32;
    localparam int NUM_BUTTONS = 4;
    localparam int NOW_BITS    = 32;
    localparam int LIMIT_BITS  = 16;
    localparam int KIND_BITS   = 4;
    localparam int INDEX_BITS  = 2;
    localparam int IN_DATA_BITS  = 40;
    localparam int OUT_DATA_BITS = 8;
    localparam int CFG_IDX_BITS  = 1;

    localparam logic [LIMIT_BITS-1:0] DEBOUNCE_RESET   = 16'd30;
    localparam logic [LIMIT_BITS-1:0] LONG_PRESS_RESET = 16'd1000;

    localparam logic [CFG_IDX_BITS-1:0] REG_DEBOUNCE   = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_LONG_PRESS = 1'd1;

    localparam logic [KIND_BITS-1:0] EV_NONE        = 4'd0;
    localparam logic [KIND_BITS-1:0] EV_CANCEL_DOWN = 4'd1;
    localparam logic [KIND_BITS-1:0] EV_SHORT_BASE  = 4'd2;
    localparam logic [KIND_BITS-1:0] EV_LONG_BASE   = 4'd3;
    localparam logic [KIND_BITS-1:0] EV_LAST        = 4'd9;

    localparam logic [INDEX_BITS-1:0] BTN_CANCEL = 2'd0;

    typedef logic [TIME_BITS-1:0]  stamp_t;
    typedef logic [LIMIT_BITS-1:0] limit_t;
    typedef logic [KIND_BITS-1:0]  kind_t;
    typedef logic [INDEX_BITS-1:0] btn_idx_t;
    typedef logic [NUM_BUTTONS-1:0][KIND_BITS-1:0] kind_vec_t;

    typedef struct packed {
        logic   accept;
        logic   resync;
        stamp_t now;
        limit_t debounce_ms;
        limit_t long_press_ms;
    } lane_cmd_t;

    function automatic logic span_reached(stamp_t now, stamp_t start, limit_t limit);
        stamp_t span;
        span = now - start;
        return span >= stamp_t'(limit);
    endfunction

    function automatic kind_t press_kind(kind_t base, btn_idx_t btn);
        return base + kind_t'({btn, 1'b0});
    endfunction

endpackage

/* rtl/fbdpc_lane.sv */
// One button's debouncer and press classifier; four copies run side by side.
// Depends on fbdpc_pkg.
module fbdpc_lane (
    input  logic                aclk,
    input  logic                aresetn,
    input  fbdpc_pkg::btn_idx_t lane_id,
    input  fbdpc_pkg::lane_cmd_t cmd,
    input  logic                level,
    output fbdpc_pkg::kind_t    ev_kind
);
    import fbdpc_pkg::*;

    logic   raw_reg,    raw_next;
    logic   stable_reg, stable_next;
    stamp_t rct_reg,    rct_next;
    stamp_t pst_reg,    pst_next;
    logic   long_reg,   long_next;
    logic   down_reg,   down_next;
    kind_t  kind;

    always_comb begin
        raw_next    = raw_reg;
        stable_next = stable_reg;
        rct_next    = rct_reg;
        pst_next    = pst_reg;
        long_next   = long_reg;
        down_next   = down_reg;
        kind        = EV_NONE;
        if (cmd.resync) begin
            raw_next    = level;
            stable_next = level;
            rct_next    = cmd.now;
            pst_next    = level ? cmd.now : '0;
            long_next   = 1'b0;
            down_next   = 1'b0;
        end else if (level != raw_reg) begin
            raw_next = level;
            rct_next = cmd.now;
        end else if (level == stable_reg) begin
            if (stable_reg && !long_reg &&
                span_reached(cmd.now, pst_reg, cmd.long_press_ms)) begin
                long_next = 1'b1;
                kind      = press_kind(EV_LONG_BASE, lane_id);
            end
        end else if (span_reached(cmd.now, rct_reg, cmd.debounce_ms)) begin
            stable_next = level;
            if (level) begin
                pst_next  = cmd.now;
                long_next = 1'b0;
                if (lane_id == BTN_CANCEL && !down_reg) begin
                    down_next = 1'b1;
                    kind      = EV_CANCEL_DOWN;
                end
            end else begin
                down_next = 1'b0;
                if (long_reg) begin
                    long_next = 1'b0;
                end else begin
                    kind = press_kind(EV_SHORT_BASE, lane_id);
                end
            end
        end
    end

    assign ev_kind = kind;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            raw_reg    <= 1'b0;
            stable_reg <= 1'b0;
            rct_reg    <= '0;
            pst_reg    <= '0;
            long_reg   <= 1'b0;
            down_reg   <= 1'b0;
        end else if (cmd.accept) begin
            raw_reg    <= raw_next;
            stable_reg <= stable_next;
            rct_reg    <= rct_next;
            pst_reg    <= pst_next;
            long_reg   <= long_next;
            down_reg   <= down_next;
        end
    end

    a_long_needs_press: assert property (@(posedge aclk) disable iff (!aresetn)
        long_reg |-> stable_reg)
        else $error("long press flag set on a released button");

    a_down_needs_press: assert property (@(posedge aclk) disable iff (!aresetn)
        down_reg |-> (stable_reg && lane_id == BTN_CANCEL))
        else $error("down flag set outside a held cancel button");

    a_resync_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.accept && cmd.resync) |=> (!long_reg && !down_reg && raw_reg == stable_reg))
        else $error("resync left stale press state");

endmodule

/* rtl/fbdpc_merge.sv */
// Picks the first lane event in button order and holds it in the output register.
// Depends on fbdpc_pkg.
module fbdpc_merge (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 accept,
    input  fbdpc_pkg::kind_vec_t lane_kinds,
    output logic                 ready,
    output logic                 out_valid,
    output fbdpc_pkg::kind_t     out_kind,
    output fbdpc_pkg::btn_idx_t  out_index,
    input  logic                 out_ready
);
    import fbdpc_pkg::*;

    logic     valid_reg;
    kind_t    kind_reg,  kind_next;
    btn_idx_t index_reg, index_next;

    always_comb begin
        kind_next  = EV_NONE;
        index_next = '0;
        for (int b = NUM_BUTTONS - 1; b >= 0; b--) begin
            if (lane_kinds[b] != EV_NONE) begin
                kind_next  = lane_kinds[b];
                index_next = btn_idx_t'(b);
            end
        end
    end

    assign ready     = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_kind  = kind_reg;
    assign out_index = index_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (accept) begin
            valid_reg <= 1'b1;
        end else if (out_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            kind_reg  <= kind_next;
            index_reg <= index_next;
        end
    end

    a_none_index_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && kind_reg == EV_NONE) |-> index_reg == '0)
        else $error("button index set on an empty word");

    a_kind_range: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg |-> kind_reg <= EV_LAST)
        else $error("event kind out of range");

    a_press_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && kind_reg >= EV_SHORT_BASE) |->
        index_reg == btn_idx_t'((kind_reg - EV_SHORT_BASE) >> 1))
        else $error("button index does not match event kind");

endmodule

/* rtl/four_button_debounce_press_classifier.sv */
// Top level: four button lanes, priority merge and the configuration registers.
// Depends on fbdpc_pkg, fbdpc_lane and fbdpc_merge.
// The output register captures a word's result when the word is accepted.
// Throughput: one word per cycle while m_tready is high; all four lanes update on acceptance.
// The output register frees in the cycle its word is taken, so input and output flow together.
// Synchronous active-low reset clears all button state and sets debounce 30 ms, long press 1000 ms.
module four_button_debounce_press_classifier (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // cancel_pressed, ok_pressed, plus_pressed, minus_pressed, now_ms[35:4], zero pad
    input  logic [fbdpc_pkg::IN_DATA_BITS-1:0]    s_tdata,
    // mode
    input  logic                                  s_tuser,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // event_kind[3:0], button_index[5:4], zero pad
    output logic [fbdpc_pkg::OUT_DATA_BITS-1:0]   m_tdata,
    input  logic                                  cfg_we,
    input  logic [fbdpc_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [fbdpc_pkg::LIMIT_BITS-1:0]      cfg_wdata
);
    import fbdpc_pkg::*;

    limit_t    debounce_reg;
    limit_t    long_press_reg;
    lane_cmd_t cmd;
    kind_vec_t lane_kinds;
    logic      merge_ready;
    kind_t     out_kind;
    btn_idx_t  out_index;
    logic [NOW_BITS-1:0] now_ms;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg   <= DEBOUNCE_RESET;
            long_press_reg <= LONG_PRESS_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_DEBOUNCE:   debounce_reg   <= cfg_wdata;
                REG_LONG_PRESS: long_press_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign s_tready          = merge_ready;
    assign now_ms            = s_tdata[NUM_BUTTONS +: NOW_BITS];
    assign cmd.accept        = s_tvalid && merge_ready;
    assign cmd.resync        = s_tuser;
    assign cmd.now           = stamp_t'(now_ms);
    assign cmd.debounce_ms   = debounce_reg;
    assign cmd.long_press_ms = long_press_reg;

    for (genvar b = 0; b < NUM_BUTTONS; b++) begin : g_lane
        fbdpc_lane u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .lane_id (btn_idx_t'(b)),
            .cmd     (cmd),
            .level   (s_tdata[b]),
            .ev_kind (lane_kinds[b])
        );
    end

    fbdpc_merge u_merge (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (cmd.accept),
        .lane_kinds (lane_kinds),
        .ready      (merge_ready),
        .out_valid  (m_tvalid),
        .out_kind   (out_kind),
        .out_index  (out_index),
        .out_ready  (m_tready)
    );

    assign m_tdata = {{(OUT_DATA_BITS - KIND_BITS - INDEX_BITS){1'b0}}, out_index, out_kind};

endmodule

/* tb/sv/tb_four_button_debounce_press_classifier.sv */
`timescale 1ns / 1ps
// Testbench for the four-button debounce and press classifier: a directed table, then random
// button traffic under several limit settings, each word checked against the predictor or a typed row's result.
// Depends on fbdpc_pkg and the top module four_button_debounce_press_classifier.
module tb_four_button_debounce_press_classifier;
    import fbdpc_pkg::*;

    localparam int HOLD_OFF_CYCLES = 300;
    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int PHASE_WORDS     = 110;
    localparam int NUM_PHASES      = 6;

    typedef struct packed {
        kind_t    kind;
        btn_idx_t btn;
    } press_result_t;

    typedef struct packed {
        logic          resync;
        logic [3:0]    levels;
        stamp_t        stamp;
        logic          typed;
        press_result_t result;
    } table_row_t;

    logic                     aclk;
    logic                     aresetn;
    logic                     s_tvalid;
    logic                     s_tready;
    logic [IN_DATA_BITS-1:0]  s_tdata;
    logic                     s_tuser;
    logic                     m_tvalid;
    logic                     m_tready;
    logic [OUT_DATA_BITS-1:0] m_tdata;
    logic                     cfg_we;
    logic [CFG_IDX_BITS-1:0]  cfg_index;
    logic [LIMIT_BITS-1:0]    cfg_wdata;

    limit_t                 debounce_limit;
    limit_t                 long_limit;
    logic [NUM_BUTTONS-1:0] raw_lvl;
    logic [NUM_BUTTONS-1:0] stable_lvl;
    logic [NUM_BUTTONS-1:0] long_seen;
    logic [NUM_BUTTONS-1:0] down_seen;
    stamp_t                 change_stamp [NUM_BUTTONS];
    stamp_t                 press_stamp [NUM_BUTTONS];

    press_result_t pending_results [$];
    table_row_t    stim_table [$];
    int            mismatches    = 0;
    int            hold_requests = 0;
    int            hold_served   = 0;
    int            hold_left     = 0;
    int            stall_cycles  = 0;
    bit            idle_on       = 1'b1;

    four_button_debounce_press_classifier dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    function automatic press_result_t classify_word(input logic resync, input logic [3:0] levels,
                                                    input stamp_t stamp);
        press_result_t res;
        kind_t         ev;
        res = '0;
        for (int b = 0; b < NUM_BUTTONS; b++) begin
            ev = EV_NONE;
            if (resync) begin
                raw_lvl[b]      = levels[b];
                stable_lvl[b]   = levels[b];
                change_stamp[b] = stamp;
                press_stamp[b]  = levels[b] ? stamp : '0;
                long_seen[b]    = 1'b0;
                down_seen[b]    = 1'b0;
            end else if (levels[b] != raw_lvl[b]) begin
                raw_lvl[b]      = levels[b];
                change_stamp[b] = stamp;
            end else if (levels[b] == stable_lvl[b]) begin
                if (stable_lvl[b] && !long_seen[b] &&
                    stamp_t'(stamp - press_stamp[b]) >= stamp_t'(long_limit)) begin
                    long_seen[b] = 1'b1;
                    ev = EV_LONG_BASE + kind_t'(2 * b);
                end
            end else if (stamp_t'(stamp - change_stamp[b]) >= stamp_t'(debounce_limit)) begin
                stable_lvl[b] = levels[b];
                if (levels[b]) begin
                    press_stamp[b] = stamp;
                    long_seen[b]   = 1'b0;
                    if (btn_idx_t'(b) == BTN_CANCEL && !down_seen[b]) begin
                        down_seen[b] = 1'b1;
                        ev = EV_CANCEL_DOWN;
                    end
                end else begin
                    down_seen[b] = 1'b0;
                    if (long_seen[b]) begin
                        long_seen[b] = 1'b0;
                    end else begin
                        ev = EV_SHORT_BASE + kind_t'(2 * b);
                    end
                end
            end
            if (ev != EV_NONE && res.kind == EV_NONE) begin
                res.kind = ev;
                res.btn  = btn_idx_t'(b);
            end
        end
        return res;
    endfunction

    task automatic add_row(input logic resync, input logic [3:0] levels, input stamp_t stamp,
                           input logic typed = 1'b0, input kind_t kind = EV_NONE,
                           input btn_idx_t btn = BTN_CANCEL);
        table_row_t row;
        row.resync = resync;
        row.levels = levels;
        row.stamp  = stamp;
        row.typed  = typed;
        row.result = '{kind: kind, btn: btn};
        stim_table.push_back(row);
    endtask

    task automatic offer_word(input logic resync, input logic [3:0] levels, input stamp_t stamp,
                              input logic typed, input press_result_t typed_result);
        press_result_t predicted;
        while (idle_on && $urandom_range(0, 99) < 26) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= resync;
        s_tdata  <= {4'b0, stamp, levels};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predicted = classify_word(resync, levels, stamp);
        pending_results.push_back(typed ? typed_result : predicted);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        @(posedge aclk);
    endtask

    task automatic write_limits(input limit_t db, input limit_t lp);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_index <= REG_DEBOUNCE;
        cfg_wdata <= db;
        @(posedge aclk);
        cfg_index <= REG_LONG_PRESS;
        cfg_wdata <= lp;
        @(posedge aclk);
        cfg_we <= 1'b0;
        debounce_limit = db;
        long_limit     = lp;
    endtask

    always @(posedge aclk) begin : result_check
        press_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected word, expected none, actual kind %0d button %0d",
                         $time, m_tdata[3:0], m_tdata[5:4]);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                if (m_tdata[3:0] !== want.kind) begin
                    $display("%0t: event_kind expected %0d actual %0d", $time,
                             want.kind, m_tdata[3:0]);
                    mismatches++;
                end
                if (m_tdata[5:4] !== want.btn) begin
                    $display("%0t: button_index expected %0d actual %0d", $time,
                             want.btn, m_tdata[5:4]);
                    mismatches++;
                end
            end
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (hold_served != hold_requests) begin
            hold_served++;
            hold_left = HOLD_OFF_CYCLES;
            m_tready <= 1'b0;
        end else begin
            m_tready <= idle_on ? ($urandom_range(0, 99) >= 26) : 1'b1;
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
        end
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("[four_button_debounce_press_classifier] ERROR");
            $finish;
        end
    end

    initial begin
        table_row_t row;
        stamp_t     clock_ms;
        logic [3:0] held;
        logic [3:0] levels;
        int         pick;
        int         sel;
        int         flip;
        int         scale;
        limit_t     phase_db [NUM_PHASES];
        limit_t     phase_lp [NUM_PHASES];

        phase_db = '{16'd0, 16'hFFFF, 16'd7, 16'd0, 16'hFFFF, 16'd30};
        phase_lp = '{16'd0, 16'hFFFF, 16'd60, 16'hFFFF, 16'd0, 16'd1000};

        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= REG_DEBOUNCE;
        cfg_wdata <= '0;

        debounce_limit = DEBOUNCE_RESET;
        long_limit     = LONG_PRESS_RESET;
        raw_lvl    = '0;
        stable_lvl = '0;
        long_seen  = '0;
        down_seen  = '0;
        for (int b = 0; b < NUM_BUTTONS; b++) begin
            change_stamp[b] = '0;
            press_stamp[b]  = '0;
        end

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Cancel: debounce edge, press, long press, release after the long event.
        add_row(1'b0, 4'b0000, 32'd0, 1'b1, EV_NONE, BTN_CANCEL);
        add_row(1'b0, 4'b0001, 32'd10);
        add_row(1'b0, 4'b0001, 32'd39);
        add_row(1'b0, 4'b0001, 32'd40, 1'b1, EV_CANCEL_DOWN, BTN_CANCEL);
        add_row(1'b0, 4'b0001, 32'd1039);
        add_row(1'b0, 4'b0001, 32'd1040, 1'b1, EV_LONG_BASE, BTN_CANCEL);
        add_row(1'b0, 4'b0000, 32'd1050);
        add_row(1'b0, 4'b0000, 32'd1080, 1'b1, EV_NONE, BTN_CANCEL);
        // A short press of ok, then plus and minus released together.
        add_row(1'b0, 4'b0010, 32'd2000);
        add_row(1'b0, 4'b0010, 32'd2030);
        add_row(1'b0, 4'b0000, 32'd2100);
        add_row(1'b0, 4'b0000, 32'd2130);
        add_row(1'b0, 4'b1100, 32'd3000);
        add_row(1'b0, 4'b1100, 32'd3030);
        add_row(1'b0, 4'b0000, 32'd3040);
        add_row(1'b0, 4'b0000, 32'd3070);
        // A bounce on minus that never settles.
        add_row(1'b0, 4'b1000, 32'd4000);
        add_row(1'b0, 4'b0000, 32'd4010);
        add_row(1'b0, 4'b0000, 32'd4100);
        // Resync near the top of the counter, then a long press across the wrap.
        add_row(1'b1, 4'b1111, 32'hFFFF_FFF0, 1'b1, EV_NONE, BTN_CANCEL);
        add_row(1'b0, 4'b1111, 32'h0000_03D7);
        add_row(1'b0, 4'b1111, 32'h0000_03D8, 1'b1, EV_LONG_BASE, BTN_CANCEL);
        add_row(1'b0, 4'b0000, 32'h0000_0400);
        add_row(1'b0, 4'b0000, 32'hFFFF_FFFF);
        add_row(1'b1, 4'b0000, 32'd0, 1'b1, EV_NONE, BTN_CANCEL);

        for (int i = 0; i < stim_table.size(); i++) begin
            row = stim_table[i];
            offer_word(row.resync, row.levels, row.stamp, row.typed, row.result);
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            write_limits(phase_db[p], phase_lp[p]);
            idle_on  = (p != 2);
            clock_ms = $urandom;
            held     = 4'($urandom);
            scale    = int'((phase_lp[p] > phase_db[p]) ? phase_lp[p] : phase_db[p]);
            for (int n = 0; n < PHASE_WORDS; n++) begin
                if (p == 3 && n == 20) begin
                    hold_requests++;
                end
                pick = $urandom_range(0, 99);
                if (pick < 3) begin
                    clock_ms += $urandom_range(0, 40);
                    held = 4'($urandom);
                    offer_word(1'b1, held, clock_ms, 1'b0, '0);
                end else if (pick < 7) begin
                    clock_ms = $urandom;
                    offer_word(1'b0, 4'($urandom), clock_ms, 1'b0, '0);
                end else begin
                    for (int b = 0; b < NUM_BUTTONS; b++) begin
                        if ($urandom_range(0, 99) < 10) begin
                            held[b] = ~held[b];
                        end
                    end
                    levels = held;
                    if ($urandom_range(0, 99) < 6) begin
                        flip = $urandom_range(0, NUM_BUTTONS - 1);
                        levels[flip] = ~levels[flip];
                    end
                    sel = $urandom_range(0, 9);
                    if (sel < 4) begin
                        clock_ms += $urandom_range(0, phase_db[p] / 2 + 1);
                    end else if (sel < 8) begin
                        clock_ms += $urandom_range(0, scale / 3 + 1);
                    end else begin
                        clock_ms += $urandom_range(0, scale + scale / 2 + 2);
                    end
                    offer_word(1'b0, levels, clock_ms, 1'b0, '0);
                end
            end
        end

        drain_results();
        repeat (5) @(posedge aclk);
        if (mismatches == 0) begin
            $display("[four_button_debounce_press_classifier] OK");
        end else begin
            $display("[four_button_debounce_press_classifier] ERROR");
        end
        $finish;
    end

endmodule
